>>> src/remote_flash_update_sequencer_defines.svh
// ----------------------------------------------------------------------------
// remote_flash_update_sequencer_defines.svh
// Assertion helpers used by the update sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef REMOTE_FLASH_UPDATE_SEQUENCER_DEFINES_SVH
`define REMOTE_FLASH_UPDATE_SEQUENCER_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define RFUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rfus_pkg.sv
// ----------------------------------------------------------------------------
// rfus_pkg
// Types and constants of the remote flash update sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfus_pkg;

  // Protocol constants
  localparam logic [8:0] MAX_CHUNK = 9'd500;
  localparam logic [7:0] OP_ERASE  = 8'd2;
  localparam logic [7:0] OP_WRITE  = 8'd3;
  localparam logic [7:0] OP_JUMP   = 8'd1;

  // Input commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RESP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Frame kinds
  typedef enum logic [1:0] {
    FK_NONE  = 2'd0,
    FK_ERASE = 2'd1,
    FK_WRITE = 2'd2,
    FK_JUMP  = 2'd3
  } frame_kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_DONE      = 3'd1,
    ST_PARAM_ERR = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_ERASE_ERR = 3'd4,
    ST_WRITE_ERR = 3'd5
  } status_e;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ERASE = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHUNK_LIMIT   = 2'd0,
    CFG_ERASE_TIMEOUT = 2'd1,
    CFG_WRITE_TIMEOUT = 2'd2,
    CFG_IMAGE_BASE    = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  target_id;
    logic [31:0] image_size;
    logic [15:0] resp_len;
    logic [7:0]  resp_opcode;
    logic [7:0]  resp_success;
    logic [31:0] resp_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  dest_id;
    logic [31:0] frame_word;
    logic [31:0] source_address;
    logic [8:0]  chunk_length;
    logic [31:0] progress_offset;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  dest_node;
    logic [31:0] total_size;
    logic [31:0] current_offset;
    logic [8:0]  current_chunk;
    logic [15:0] elapsed_ticks;
  } state_t;

  typedef struct packed {
    logic [8:0]  chunk_limit;
    logic [15:0] erase_timeout_ms;
    logic [15:0] write_timeout_ms;
    logic [31:0] image_base_address;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/rfus_step.sv
// ----------------------------------------------------------------------------
// rfus_step
// Next-state and result logic for one item of the update sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rfus_step import rfus_pkg::*; (
  input  state_t    state_i,
  input  cfg_t      cfg_i,
  input  in_item_t  item_i,
  output state_t    state_o,
  output logic      emit_o,
  output out_item_t result_o
);

  logic [8:0]  lim;
  logic [31:0] sum_off;
  logic [31:0] wr_off;
  logic [31:0] remain;
  logic [8:0]  wr_chunk;
  logic [15:0] ticks_inc;
  logic [15:0] tmo_limit;
  logic        op_known;
  logic        erase_ok;
  logic        write_ok;

  // Shared datapath: chunk sizing, offset advance, tick count, timeout limit, response checks
  always_comb begin
    lim = ((cfg_i.chunk_limit == 9'd0) || (cfg_i.chunk_limit > MAX_CHUNK))
          ? MAX_CHUNK : cfg_i.chunk_limit;
    sum_off  = state_i.current_offset + {23'd0, state_i.current_chunk};
    wr_off   = (state_i.phase == PH_WRITE) ? sum_off : state_i.current_offset;
    remain   = state_i.total_size - wr_off;
    wr_chunk = (remain < {23'd0, lim}) ? remain[8:0] : lim;
    ticks_inc = (state_i.elapsed_ticks == 16'hFFFF) ? 16'hFFFF
                : state_i.elapsed_ticks + 16'd1;
    tmo_limit = (state_i.phase == PH_ERASE) ? cfg_i.erase_timeout_ms
                : cfg_i.write_timeout_ms;
    op_known = (item_i.resp_opcode == OP_ERASE) || (item_i.resp_opcode == OP_WRITE);
    erase_ok = (item_i.resp_len >= 16'd2) && (item_i.resp_opcode == OP_ERASE) &&
               (item_i.resp_success == 8'd1);
    write_ok = (item_i.resp_len >= 16'd6) && (item_i.resp_opcode == OP_WRITE) &&
               (item_i.resp_success == 8'd1) &&
               (item_i.resp_offset == state_i.current_offset);
  end

  // Command decode
  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '0;
    result_o.progress_offset = state_i.current_offset;
    unique case (item_i.cmd)
      CMD_START: begin
        emit_o = 1'b1;
        state_o.current_offset = '0;
        state_o.current_chunk  = '0;
        state_o.elapsed_ticks  = '0;
        result_o.progress_offset = '0;
        if (item_i.image_size == 32'd0) begin
          state_o.total_size = '0;
          state_o.phase      = PH_IDLE;
          result_o.status    = ST_PARAM_ERR;
        end else begin
          state_o.dest_node   = item_i.target_id;
          state_o.total_size  = item_i.image_size;
          state_o.phase       = PH_ERASE;
          result_o.frame_kind = FK_ERASE;
          result_o.dest_id    = item_i.target_id;
          result_o.frame_word = item_i.image_size;
          result_o.status     = ST_BUSY;
        end
      end
      CMD_RESP: begin
        if ((state_i.phase != PH_IDLE) && (item_i.resp_len != 16'd0) && op_known) begin
          emit_o = 1'b1;
          if ((state_i.phase == PH_ERASE) && !erase_ok) begin
            state_o.phase   = PH_IDLE;
            result_o.status = ST_ERASE_ERR;
          end else if ((state_i.phase == PH_WRITE) && !write_ok) begin
            state_o.phase   = PH_IDLE;
            result_o.status = ST_WRITE_ERR;
          end else if ((state_i.phase == PH_WRITE) && (sum_off >= state_i.total_size)) begin
            // last chunk acknowledged: hand over to the bootloader
            state_o.current_offset   = sum_off;
            state_o.phase            = PH_IDLE;
            state_o.elapsed_ticks    = '0;
            result_o.frame_kind      = FK_JUMP;
            result_o.dest_id         = state_i.dest_node;
            result_o.progress_offset = sum_off;
            result_o.status          = ST_DONE;
          end else begin
            // next write request
            state_o.current_offset   = wr_off;
            state_o.current_chunk    = wr_chunk;
            state_o.elapsed_ticks    = '0;
            state_o.phase            = PH_WRITE;
            result_o.frame_kind      = FK_WRITE;
            result_o.dest_id         = state_i.dest_node;
            result_o.frame_word      = wr_off;
            result_o.source_address  = cfg_i.image_base_address + wr_off;
            result_o.chunk_length    = wr_chunk;
            result_o.progress_offset = wr_off;
            result_o.status          = ST_BUSY;
          end
        end
      end
      CMD_TICK: begin
        if (state_i.phase != PH_IDLE) begin
          state_o.elapsed_ticks = ticks_inc;
          if (ticks_inc >= tmo_limit) begin
            emit_o          = 1'b1;
            state_o.phase   = PH_IDLE;
            result_o.status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/remote_flash_update_sequencer.sv
// ----------------------------------------------------------------------------
// remote_flash_update_sequencer: items pass an input register, then a result register.
// Throughput one item per cycle; input stalls only when a new result meets one still held.
// Reset clears the phase and all progress state; config returns to its defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "remote_flash_update_sequencer_defines.svh"

module remote_flash_update_sequencer import rfus_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item input
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t      cfg_q;
  state_t    state_q;
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;

  state_t    step_state;
  logic      step_emit;
  out_item_t step_res;
  logic      stall;
  logic      adv;

  // Per-item logic
  rfus_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .state_o  (step_state),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  // Handshake: the stage holds only when its result cannot be parked
  assign stall      = in_valid_q && step_emit && out_valid_q && !out_ready_i;
  assign adv        = in_valid_q && !stall;
  assign in_ready_o = !in_valid_q || !stall;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_limit        <= 9'd500;
      cfg_q.erase_timeout_ms   <= 16'd15000;
      cfg_q.write_timeout_ms   <= 16'd5000;
      cfg_q.image_base_address <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHUNK_LIMIT:   cfg_q.chunk_limit        <= cfg_data_i[8:0];
        CFG_ERASE_TIMEOUT: cfg_q.erase_timeout_ms   <= cfg_data_i[15:0];
        CFG_WRITE_TIMEOUT: cfg_q.write_timeout_ms   <= cfg_data_i[15:0];
        CFG_IMAGE_BASE:    cfg_q.image_base_address <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (adv) begin
      state_q <= step_state;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && step_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (adv && step_emit) begin
      out_q <= step_res;
    end
  end

  // Checks
  `RFUS_ASSERT_NEXT(a_busy_keeps_running,
    adv && step_emit && (step_res.status == ST_BUSY),
    state_q.phase != PH_IDLE, "busy result but sequencer went idle")
  `RFUS_ASSERT_NEXT(a_final_goes_idle,
    adv && step_emit && (step_res.status != ST_BUSY),
    state_q.phase == PH_IDLE, "final result but sequencer still running")
  `RFUS_ASSERT(a_chunk_in_range,
    (state_q.phase != PH_WRITE) ||
    ((state_q.current_chunk != 9'd0) && (state_q.current_chunk <= MAX_CHUNK)),
    "outstanding chunk length out of range")
  `RFUS_ASSERT_NEXT(a_stall_holds_item, stall, in_valid_q && $stable(in_q),
    "stalled item lost or changed")

endmodule

`default_nettype wire
